[sv/ssnp_pkg.sv]
package ssnp_pkg;

  // Depth of the queue between the classifier and the parser.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Suffix scale shifts.
  localparam logic [5:0] SH_KILO = 6'd10;
  localparam logic [5:0] SH_MEGA = 6'd20;
  localparam logic [5:0] SH_GIGA = 6'd30;
  localparam logic [5:0] SH_TERA = 6'd40;
  localparam logic [5:0] SH_PETA = 6'd50;
  localparam logic [5:0] SH_EXA  = 6'd60;

  // A character after classification.
  typedef struct packed {
    logic       term;      // NUL byte, ends the string
    logic       space;     // blank or control whitespace
    logic       plus;
    logic       minus;
    logic       digit_ok;  // 0-9, a-f or A-F
    logic [3:0] dval;      // digit value when digit_ok
    logic       is_x;      // x or X
    logic       sfx_ok;    // K M G T P E, either case
    logic [5:0] sfx_shift;
    logic       is_b;      // b or B
  } tok_t;

endpackage

[sv/size_suffix_number_parser.sv]
// A terminating word's result is offered once the word, written into the
// queue on acceptance, has reached the head of the queue and been popped
// straight into the parser's result register.
// Throughput: one word per cycle unless the queue is full; the parser retires
// one queued word a cycle, and only a terminator waits on a full result register.
// Reset (rst, synchronous, active high) empties the queue, drops any pending
// result and returns the parser to its leading-whitespace phase.
module size_suffix_number_parser import ssnp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  logic [7:0]         char_in,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [63:0] value,
  output logic [1:0]         status,
  output logic               clamped
);

  // The front end decodes each incoming character into a small set of class
  // flags (digit with its value, sign, whitespace, suffix with its shift,
  // and so on), so the parser never looks at raw bytes.
  tok_t in_tok;
  tok_t head_tok;
  logic q_full;
  logic q_nonempty;
  logic q_pop;
  logic q_push;

  ssnp_front u_front (
    .char_in (char_in),
    .tok     (in_tok)
  );

  // A short queue decouples the two halves: words keep flowing in while a
  // finished result waits for the downstream side to take it.
  assign q_push     = char_valid && !q_full;
  assign char_stall = q_full;

  ssnp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_tok (in_tok),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (head_tok)
  );

  // The back end runs the scanning state machine, the saturating
  // multiply-add of the digits and, on a terminator, the suffix scaling
  // with its range check, which lands in the result register.
  ssnp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .nonempty     (q_nonempty),
    .head         (head_tok),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .status       (status),
    .clamped      (clamped)
  );

endmodule

[sv/ssnp_front.sv]
module ssnp_front import ssnp_pkg::*; (
  input  logic [7:0] char_in,
  output tok_t       tok
);

  always_comb begin
    tok           = '0;
    tok.term      = (char_in == 8'd0);
    tok.space     = (char_in == 8'd32) || (char_in >= 8'd9 && char_in <= 8'd13);
    tok.plus      = (char_in == 8'h2B);
    tok.minus     = (char_in == 8'h2D);
    tok.is_x      = (char_in == 8'h78) || (char_in == 8'h58);
    tok.is_b      = (char_in == 8'h62) || (char_in == 8'h42);
    if (char_in >= 8'h30 && char_in <= 8'h39) begin
      tok.digit_ok = 1'b1;
      tok.dval     = 4'(char_in - 8'h30);
    end else if (char_in >= 8'h61 && char_in <= 8'h66) begin
      tok.digit_ok = 1'b1;
      tok.dval     = 4'(char_in - 8'h57);
    end else if (char_in >= 8'h41 && char_in <= 8'h46) begin
      tok.digit_ok = 1'b1;
      tok.dval     = 4'(char_in - 8'h37);
    end
    unique case (char_in) inside
      8'h6B, 8'h4B: begin tok.sfx_ok = 1'b1; tok.sfx_shift = SH_KILO; end
      8'h6D, 8'h4D: begin tok.sfx_ok = 1'b1; tok.sfx_shift = SH_MEGA; end
      8'h67, 8'h47: begin tok.sfx_ok = 1'b1; tok.sfx_shift = SH_GIGA; end
      8'h74, 8'h54: begin tok.sfx_ok = 1'b1; tok.sfx_shift = SH_TERA; end
      8'h70, 8'h50: begin tok.sfx_ok = 1'b1; tok.sfx_shift = SH_PETA; end
      8'h65, 8'h45: begin tok.sfx_ok = 1'b1; tok.sfx_shift = SH_EXA;  end
      default: ;
    endcase
  end

endmodule

[sv/ssnp_queue.sv]
module ssnp_queue import ssnp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_tok,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output tok_t head
);

  tok_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'((QPTR_W + 1)'(wr_ptr) + 1'b1 == (QPTR_W + 1)'(QDEPTH) ?
                          0 : wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QPTR_W'((QPTR_W + 1)'(rd_ptr) + 1'b1 == (QPTR_W + 1)'(QDEPTH) ?
                          0 : rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/ssnp_back.sv]
module ssnp_back import ssnp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               nonempty,
  input  tok_t               head,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [63:0] value,
  output logic [1:0]         status,
  output logic               clamped
);

  localparam logic [2:0] PH_WS     = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_X      = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_SUFFIX = 3'd5;
  localparam logic [2:0] PH_BYTE   = 3'd6;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

  logic [2:0]  scan_phase, scan_phase_next;
  logic [1:0]  radix_sel, radix_sel_next;
  logic        is_negative, is_negative_next;
  logic [63:0] magnitude, magnitude_next;
  logic        overflowed, overflowed_next;
  logic [5:0]  scale_shift, scale_shift_next;
  logic        format_bad, format_bad_next;

  // Accumulator request from the phase decoder.
  logic        acc_en;
  logic [1:0]  acc_radix;
  logic [3:0]  acc_d;
  logic [67:0] mag_x, prod, sum;
  logic [63:0] limit;

  logic        fin_bad;
  logic [63:0] fin_lim;
  logic [63:0] fin_signed;
  logic [63:0] fin_value;
  logic [1:0]  fin_status;
  logic        fin_clamp;
  logic        digit_here;

  // A terminator needs the output register; other words always drain.
  assign pop = nonempty && (!head.term || !result_valid || !result_stall);

  // Multiply-add by the radix with a saturation check: the product and digit
  // are summed one step wide and compared against the signed limit.
  assign limit = is_negative ? LIM_NEG : LIM_POS;
  assign mag_x = {4'd0, magnitude};
  always_comb begin
    case (acc_radix)
      RADIX_OCT: prod = mag_x << 3;
      RADIX_HEX: prod = mag_x << 4;
      default:   prod = (mag_x << 3) + (mag_x << 1);
    endcase
  end
  assign sum = prod + {64'd0, acc_d};

  always_comb begin
    case (radix_sel)
      RADIX_OCT: digit_here = head.digit_ok && (head.dval <= 4'd7);
      RADIX_HEX: digit_here = head.digit_ok;
      default:   digit_here = head.digit_ok && (head.dval <= 4'd9);
    endcase
  end

  always_comb begin
    scan_phase_next  = scan_phase;
    radix_sel_next   = radix_sel;
    is_negative_next = is_negative;
    scale_shift_next = scale_shift;
    format_bad_next  = format_bad;
    acc_en           = 1'b0;
    acc_radix        = radix_sel;
    acc_d            = head.dval;

    if (!format_bad) begin
      unique case (scan_phase) inside
        PH_WS, PH_SIGN: begin
          if (scan_phase == PH_WS && head.space) begin
            scan_phase_next = PH_WS;
          end else if (scan_phase == PH_WS && (head.plus || head.minus)) begin
            is_negative_next = head.minus;
            scan_phase_next  = PH_SIGN;
          end else if (head.digit_ok && head.dval == 4'd0) begin
            scan_phase_next = PH_ZERO;
          end else if (head.digit_ok && head.dval <= 4'd9) begin
            radix_sel_next  = RADIX_DEC;
            scan_phase_next = PH_DIGITS;
            acc_en          = 1'b1;
            acc_radix       = RADIX_DEC;
          end else begin
            format_bad_next = 1'b1;
          end
        end
        PH_ZERO: begin
          if (head.is_x) begin
            radix_sel_next  = RADIX_HEX;
            scan_phase_next = PH_X;
          end else if (head.digit_ok && head.dval <= 4'd7) begin
            radix_sel_next  = RADIX_OCT;
            scan_phase_next = PH_DIGITS;
            acc_en          = 1'b1;
            acc_radix       = RADIX_OCT;
          end else if (head.sfx_ok) begin
            scale_shift_next = head.sfx_shift;
            scan_phase_next  = PH_SUFFIX;
          end else begin
            format_bad_next = 1'b1;
          end
        end
        PH_X: begin
          if (head.digit_ok) begin
            scan_phase_next = PH_DIGITS;
            acc_en          = 1'b1;
          end else begin
            format_bad_next = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (digit_here) begin
            acc_en = 1'b1;
          end else if (head.sfx_ok) begin
            scale_shift_next = head.sfx_shift;
            scan_phase_next  = PH_SUFFIX;
          end else begin
            format_bad_next = 1'b1;
          end
        end
        PH_SUFFIX: begin
          if (head.is_b) begin
            scan_phase_next = PH_BYTE;
          end else begin
            format_bad_next = 1'b1;
          end
        end
        default: begin
          format_bad_next = 1'b1;
        end
      endcase
    end

    magnitude_next  = magnitude;
    overflowed_next = overflowed;
    if (acc_en && !overflowed) begin
      if (sum > {4'd0, limit}) begin
        overflowed_next = 1'b1;
        magnitude_next  = limit;
      end else begin
        magnitude_next = sum[63:0];
      end
    end
  end

  // Result of a terminator: the range check works on the limit shifted
  // down, so the scaled value never needs more than 64 bits.
  assign fin_bad    = format_bad || scan_phase == PH_WS || scan_phase == PH_SIGN ||
                      scan_phase == PH_X || scan_phase > PH_BYTE;
  assign fin_lim    = limit >> scale_shift;
  assign fin_signed = is_negative ? (64'd0 - magnitude) : magnitude;
  always_comb begin
    fin_value  = '0;
    fin_status = ST_OK;
    fin_clamp  = 1'b0;
    if (fin_bad) begin
      fin_status = ST_BAD;
    end else begin
      fin_clamp = overflowed;
      if (magnitude > fin_lim) begin
        fin_status = ST_RANGE;
      end else begin
        fin_value = fin_signed << scale_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase   <= PH_WS;
      radix_sel    <= RADIX_DEC;
      is_negative  <= 1'b0;
      magnitude    <= '0;
      overflowed   <= 1'b0;
      scale_shift  <= '0;
      format_bad   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (pop) begin
        if (head.term) begin
          result_valid <= 1'b1;
          scan_phase   <= PH_WS;
          radix_sel    <= RADIX_DEC;
          is_negative  <= 1'b0;
          magnitude    <= '0;
          overflowed   <= 1'b0;
          scale_shift  <= '0;
          format_bad   <= 1'b0;
        end else begin
          scan_phase   <= scan_phase_next;
          radix_sel    <= radix_sel_next;
          is_negative  <= is_negative_next;
          magnitude    <= magnitude_next;
          overflowed   <= overflowed_next;
          scale_shift  <= scale_shift_next;
          format_bad   <= format_bad_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.term) begin
      value   <= fin_value;
      status  <= fin_status;
      clamped <= fin_clamp;
    end
  end

endmodule
